// ----- hdl/mi3_pkg.sv -----
// ---------------------------------------------------------------------------
// mi3_pkg: shared types and constants for the 3x3 matrix inverse
// Word formats, internal widths and the lane result record.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mi3_pkg;

   // Element format is fixed by the field widths of the words.
   localparam int ELEM_W       = 32;
   localparam int DIM          = 3;
   localparam int NUM_ELEMS    = DIM * DIM;
   localparam int NUM_PRODS    = 2 * NUM_ELEMS;
   localparam int PROD_W       = 2 * ELEM_W;
   localparam int COF_W        = 2 * ELEM_W + 1;
   localparam int COF_MAG_W    = 2 * ELEM_W;
   localparam int PART_W       = 2 * ELEM_W + 1;
   localparam int DET_W        = 3 * ELEM_W + 2;
   localparam int DET_MAG_W    = 3 * ELEM_W;
   localparam int FRONT_STAGES = 6;

   typedef logic signed [ELEM_W-1:0] elem_type;

   typedef struct packed {
      elem_type a00;
      elem_type a01;
      elem_type a02;
      elem_type a10;
      elem_type a11;
      elem_type a12;
      elem_type a20;
      elem_type a21;
      elem_type a22;
   } req_word_type;

   typedef struct packed {
      elem_type b00;
      elem_type b01;
      elem_type b02;
      elem_type b10;
      elem_type b11;
      elem_type b12;
      elem_type b20;
      elem_type b21;
      elem_type b22;
      elem_type det_value;
      logic     singular;
   } rsp_word_type;

   // Determinant as sign and magnitude.
   typedef struct packed {
      logic                 neg;
      logic [DET_MAG_W-1:0] mag;
   } det_info_type;

   // Quotient of one divider lane before saturation.
   typedef struct packed {
      logic              neg;
      logic              ovf;
      logic [ELEM_W-1:0] q;
   } quo_type;

endpackage

`default_nettype wire

// ----- hdl/mi3_adj.sv -----
// ---------------------------------------------------------------------------
// mi3_adj: adjugate and determinant front end
// Six register stages: input, cross products, cofactors, determinant
// partial products, determinant sum, and sign/magnitude split.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mi3_adj import mi3_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 en,
   input  wire req_word_type         req_word,
   output logic [COF_MAG_W-1:0]      cof_mag [NUM_ELEMS],
   output logic [NUM_ELEMS-1:0]      cof_neg,
   output det_info_type              det_info
);

   // Operand pairs: cofactor j is prod[2j] - prod[2j+1], element index r*3+c.
   localparam int MUL_L [NUM_PRODS] = '{4, 7, 2, 1, 1, 2, 5, 3, 0,
                                        2, 3, 0, 3, 6, 6, 0, 0, 3};
   localparam int MUL_R [NUM_PRODS] = '{8, 5, 7, 8, 5, 4, 6, 8, 8,
                                        6, 2, 5, 7, 4, 1, 7, 4, 1};

   elem_type                 a_ff      [NUM_ELEMS];
   logic signed [PROD_W-1:0] prod_ff   [NUM_PRODS];
   elem_type                 row0_b_ff [DIM];
   elem_type                 row0_c_ff [DIM];
   logic signed [COF_W-1:0]  cof_c_ff  [NUM_ELEMS];
   logic signed [COF_W-1:0]  cof_d_ff  [NUM_ELEMS];
   logic signed [COF_W-1:0]  cof_e_ff  [NUM_ELEMS];
   logic signed [PART_W-1:0] plo_in    [DIM];
   logic signed [PART_W-1:0] phi_in    [DIM];
   logic signed [PART_W-1:0] plo_ff    [DIM];
   logic signed [PART_W-1:0] phi_ff    [DIM];
   logic signed [DET_W-1:0]  det_in;
   logic signed [DET_W-1:0]  det_ff;
   logic [COF_MAG_W-1:0]     cof_mag_ff [NUM_ELEMS];
   logic [NUM_ELEMS-1:0]     cof_neg_ff;
   det_info_type             det_info_ff;

   // Determinant partial products: each of the three cofactors used (indices 0,
   // 3 and 6) is split into a low unsigned half and a high signed half to keep multipliers narrow.
   always_comb begin
      logic signed [ELEM_W:0] lo_s;
      logic signed [ELEM_W:0] hi_s;
      for (int k = 0; k < DIM; k++) begin
         lo_s      = $signed({1'b0, cof_c_ff[DIM*k][ELEM_W-1:0]});
         hi_s      = $signed(cof_c_ff[DIM*k][COF_W-1:ELEM_W]);
         plo_in[k] = row0_c_ff[k] * lo_s;
         phi_in[k] = row0_c_ff[k] * hi_s;
      end
   end

   // Determinant sum of the three first-row terms.
   always_comb begin
      logic signed [DET_W-1:0] acc;
      acc = '0;
      for (int k = 0; k < DIM; k++) begin
         acc = acc + (DET_W'(phi_ff[k]) <<< ELEM_W) + DET_W'(plo_ff[k]);
      end
      det_in = acc;
   end

   // Pipeline registers, all held while the output side stalls.
   always_ff @(posedge clock) begin
      if (en) begin
         a_ff[0] <= req_word.a00;
         a_ff[1] <= req_word.a01;
         a_ff[2] <= req_word.a02;
         a_ff[3] <= req_word.a10;
         a_ff[4] <= req_word.a11;
         a_ff[5] <= req_word.a12;
         a_ff[6] <= req_word.a20;
         a_ff[7] <= req_word.a21;
         a_ff[8] <= req_word.a22;
         for (int p = 0; p < NUM_PRODS; p++) begin
            prod_ff[p] <= a_ff[MUL_L[p]] * a_ff[MUL_R[p]];
         end
         for (int k = 0; k < DIM; k++) begin
            row0_b_ff[k] <= a_ff[k];
            row0_c_ff[k] <= row0_b_ff[k];
            plo_ff[k]    <= plo_in[k];
            phi_ff[k]    <= phi_in[k];
         end
         for (int j = 0; j < NUM_ELEMS; j++) begin
            cof_c_ff[j]   <= COF_W'(prod_ff[2*j]) - COF_W'(prod_ff[2*j+1]);
            cof_d_ff[j]   <= cof_c_ff[j];
            cof_e_ff[j]   <= cof_d_ff[j];
            cof_neg_ff[j] <= cof_e_ff[j][COF_W-1];
            cof_mag_ff[j] <= cof_e_ff[j][COF_W-1] ? COF_MAG_W'(-cof_e_ff[j])
                                                  : COF_MAG_W'(cof_e_ff[j]);
         end
         det_ff          <= det_in;
         det_info_ff.neg <= det_ff[DET_W-1];
         det_info_ff.mag <= det_ff[DET_W-1] ? DET_MAG_W'(-det_ff) : DET_MAG_W'(det_ff);
      end
   end

   assign cof_mag  = cof_mag_ff;
   assign cof_neg  = cof_neg_ff;
   assign det_info = det_info_ff;

endmodule

`default_nettype wire

// ----- hdl/mi3_div_lane.sv -----
// ---------------------------------------------------------------------------
// mi3_div_lane: pipelined restoring divider for one inverse element
// Divides the scaled cofactor magnitude by the determinant magnitude,
// one quotient bit per stage after an overflow check stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mi3_div_lane import mi3_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 en,
   input  wire logic [COF_MAG_W-1:0] num_mag,
   input  wire logic                 num_neg,
   input  wire det_info_type         det_info,
   output quo_type                   quo
);

   localparam int CW = 4 * ELEM_W;

   logic [CW-1:0]        rem_in [ELEM_W];
   logic [CW-1:0]        rem_ff [ELEM_W];
   logic [DET_MAG_W-1:0] dv_ff  [ELEM_W];
   logic [ELEM_W-1:0]    q_in   [ELEM_W+1];
   logic [ELEM_W-1:0]    q_ff   [ELEM_W+1];
   logic [ELEM_W:0]      ovf_ff;
   logic [ELEM_W:0]      neg_ff;
   logic                 ovf_in;

   // Overflow check: the quotient does not fit when num >= det * 2^ELEM_W.
   assign ovf_in = rem_in[0] >= (CW'(det_info.mag) << ELEM_W);

   // One trial subtraction per stage, quotient bit ELEM_W-k at stage k.
   always_comb begin
      logic [CW-1:0] dsh;
      logic          take;
      rem_in[0] = CW'(num_mag) << (2 * FRAC_BITS);
      q_in[0]   = '0;
      for (int k = 1; k <= ELEM_W; k++) begin
         dsh  = CW'(dv_ff[k-1]) << (ELEM_W - k);
         take = rem_ff[k-1] >= dsh;
         q_in[k] = q_ff[k-1];
         q_in[k][ELEM_W-k] = take;
         if (k < ELEM_W) begin
            rem_in[k] = take ? (rem_ff[k-1] - dsh) : rem_ff[k-1];
         end
      end
   end

   // Stage registers.
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < ELEM_W; k++) begin
            rem_ff[k] <= rem_in[k];
         end
         for (int k = 0; k <= ELEM_W; k++) begin
            q_ff[k] <= q_in[k];
         end
         dv_ff[0] <= det_info.mag;
         for (int k = 1; k < ELEM_W; k++) begin
            dv_ff[k] <= dv_ff[k-1];
         end
         ovf_ff <= {ovf_ff[ELEM_W-1:0], ovf_in};
         neg_ff <= {neg_ff[ELEM_W-1:0], num_neg ^ det_info.neg};
      end
   end

   assign quo.q   = q_ff[ELEM_W];
   assign quo.ovf = ovf_ff[ELEM_W];
   assign quo.neg = neg_ff[ELEM_W];

endmodule

`default_nettype wire

// ----- hdl/mi3_merge.sv -----
// ---------------------------------------------------------------------------
// mi3_merge: result assembly and output register
// Saturates the lane quotients and the determinant, applies the singular
// case and holds the result word until it is taken.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mi3_merge import mi3_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         en,
   input  wire logic         vld_last,
   input  wire quo_type      quo [NUM_ELEMS],
   input  wire det_info_type det_info,
   output logic              rsp_valid,
   output rsp_word_type      rsp_word
);

   localparam logic [ELEM_W-1:0]    MIN_MAG   = ELEM_W'(1) << (ELEM_W - 1);
   localparam logic [ELEM_W-1:0]    ELEM_MAX  = MIN_MAG - ELEM_W'(1);
   localparam logic [DET_MAG_W-1:0] DET_NLIM  = DET_MAG_W'(1) << (ELEM_W - 1);
   localparam logic [DET_MAG_W-1:0] DET_PLIM  = DET_NLIM - DET_MAG_W'(1);

   det_info_type          det_dly_ff [ELEM_W+1];
   det_info_type          det_cur;
   logic [DET_MAG_W-1:0]  det_sh;
   logic                  singular;
   elem_type              b_val [NUM_ELEMS];
   elem_type              det_val;
   rsp_word_type          rsp_in;
   rsp_word_type          rsp_word_ff;
   logic                  rsp_valid_ff;

   // Saturate a signed quotient given as sign, overflow and magnitude.
   function automatic elem_type sat_quo(input quo_type x);
      elem_type r;
      if (x.neg) begin
         r = (x.ovf || (x.q > MIN_MAG)) ? elem_type'(MIN_MAG) : elem_type'(-x.q);
      end else begin
         r = (x.ovf || x.q[ELEM_W-1]) ? elem_type'(ELEM_MAX) : elem_type'(x.q);
      end
      return r;
   endfunction

   assign det_cur  = det_dly_ff[ELEM_W];
   assign det_sh   = det_cur.mag >> (2 * FRAC_BITS);
   assign singular = det_cur.mag == '0;

   // Result word: saturated quotients and determinant, or zeros and the flag for a singular matrix.
   always_comb begin
      if (det_cur.neg) begin
         det_val = (det_sh > DET_NLIM) ? elem_type'(MIN_MAG)
                                       : elem_type'(ELEM_W'(0) - det_sh[ELEM_W-1:0]);
      end else begin
         det_val = (det_sh > DET_PLIM) ? elem_type'(ELEM_MAX)
                                       : elem_type'(det_sh[ELEM_W-1:0]);
      end
      for (int j = 0; j < NUM_ELEMS; j++) begin
         b_val[j] = singular ? '0 : sat_quo(quo[j]);
      end
      rsp_in.b00       = b_val[0];
      rsp_in.b01       = b_val[1];
      rsp_in.b02       = b_val[2];
      rsp_in.b10       = b_val[3];
      rsp_in.b11       = b_val[4];
      rsp_in.b12       = b_val[5];
      rsp_in.b20       = b_val[6];
      rsp_in.b21       = b_val[7];
      rsp_in.b22       = b_val[8];
      rsp_in.det_value = singular ? '0 : det_val;
      rsp_in.singular  = singular;
   end

   // Determinant delay matching the divider lanes.
   always_ff @(posedge clock) begin
      if (en) begin
         det_dly_ff[0] <= det_info;
         for (int k = 1; k <= ELEM_W; k++) begin
            det_dly_ff[k] <= det_dly_ff[k-1];
         end
         rsp_word_ff <= rsp_in;
      end
   end

   // Output word valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= vld_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

`default_nettype wire

// ----- hdl/matrix_inverse_3x3.sv -----
// Throughput: one word per cycle unless the output stalls; the adjugate front
// end, the nine divider lanes (one quotient bit per stage) and the output
// register all advance together.
// A stalled output word holds the whole pipeline until it is taken.
// Reset clears the valid bits only; the data registers are not reset.
// ---------------------------------------------------------------------------
// matrix_inverse_3x3: pipelined 3x3 fixed-point matrix inverse
// Adjugate over determinant with nine parallel divider lanes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module matrix_inverse_3x3 import mi3_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_word_type req_word,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_word_type      rsp_word
);

   localparam int VLD_N = FRONT_STAGES + ELEM_W + 1;

   logic                 en;
   logic [VLD_N-1:0]     vld_ff;
   logic [COF_MAG_W-1:0] cof_mag [NUM_ELEMS];
   logic [NUM_ELEMS-1:0] cof_neg;
   det_info_type         det_info;
   quo_type              quo [NUM_ELEMS];

   // The pipeline moves unless a finished word is held at the output.
   assign en        = !rsp_valid || !rsp_stall;
   assign req_stall = !en;

   // Valid bits alongside the data pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[VLD_N-2:0], req_valid};
      end
   end

   mi3_adj u_adj (
      .clock    (clock),
      .en       (en),
      .req_word (req_word),
      .cof_mag  (cof_mag),
      .cof_neg  (cof_neg),
      .det_info (det_info)
   );

   // One divider lane per inverse element.
   for (genvar j = 0; j < NUM_ELEMS; j++) begin : g_lane
      mi3_div_lane #(
         .FRAC_BITS (FRAC_BITS)
      ) u_lane (
         .clock    (clock),
         .en       (en),
         .num_mag  (cof_mag[j]),
         .num_neg  (cof_neg[j]),
         .det_info (det_info),
         .quo      (quo[j])
      );
   end

   mi3_merge #(
      .FRAC_BITS (FRAC_BITS)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .vld_last  (vld_ff[VLD_N-1]),
      .quo       (quo),
      .det_info  (det_info),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

endmodule

`default_nettype wire
